### hdl/cur_pkg.sv
// cur_pkg: shared types, register indexes and a helper for the chroma
// upsampler by pixel replication. No dependencies.
`default_nettype none

package cur_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_H_FACTOR   = 2'd0;
  localparam logic [1:0] REG_V_FACTOR   = 2'd1;
  localparam logic [1:0] REG_BLK_PER_ROW = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned FACTOR_W   = 3;
  localparam int unsigned COORD_W    = 13;  // full-resolution pixel coordinate

  // input transaction
  typedef struct packed {
    logic [7:0] sample;
    logic [7:0] block_col;
    logic [7:0] block_row;
    logic [2:0] col_in_block;
    logic [2:0] row_in_block;
  } cur_in_t;

  // result transaction
  typedef struct packed {
    logic [7:0]  sample_out;
    logic [15:0] out_block;
    logic [2:0]  out_col;
    logic [2:0]  out_row;
    logic        last;
  } cur_out_t;

  // job handed from the front to the back through the queue
  typedef struct packed {
    logic [7:0]         sample;
    logic [COORD_W-1:0] base_x;
    logic [COORD_W-1:0] base_y;
    logic [1:0]         hf_m1;
    logic [1:0]         vf_m1;
  } cur_job_t;

  // register value to factor minus one: zero acts as one, above four as four
  function automatic logic [1:0] clamp_factor_m1(input logic [FACTOR_W-1:0] f);
    logic [1:0] r;
    if (f == 3'd0) begin
      r = 2'd0;
    end else if (f > 3'd4) begin
      r = 2'd3;
    end else begin
      r = 2'(f - 3'd1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/chroma_upsample_replicate.sv
// chroma_upsample_replicate: top level, configuration registers and the
// front / queue / back chain. Depends on cur_pkg, cur_front, cur_queue, cur_back.
//
//   channel  ports                           dir  transaction
//   input    in_push  in_full  in_item        in   one sample with its position
//   result   out_pop  out_empty out_item      out  one replica with destination
//   config   cfg_we   cfg_index cfg_data      in   one register write
//
// An input makes h_factor * v_factor replicas after clamping (1 to 16, 4 for 2x2) in the back
// part, which emits one replica per cycle while the result slot is free or being drained; the front
// takes a new input every cycle while the job queue (QUEUE_DEPTH entries) has room.
// Reset is synchronous on rst_n: queue empty, offsets zero, result slot empty,
// factors 1 and blocks per row 1.
// A stalled result holds the back part; the queue then absorbs inputs until full.
`default_nettype none

module chroma_upsample_replicate #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  input  wire cur_pkg::cur_in_t               in_item,
  output logic                                in_full,
  output logic                                out_empty,
  output cur_pkg::cur_out_t                   out_item,
  input  wire logic                           out_pop,
  input  wire logic                           cfg_we,
  input  wire logic [cur_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cur_pkg::CFG_DATA_W-1:0] cfg_data
);

  import cur_pkg::*;

  logic [FACTOR_W-1:0]   h_factor_r, v_factor_r;
  logic [CFG_DATA_W-1:0] blk_per_row_r;
  cur_job_t              fr_job, q_job;
  logic                  fr_push, q_full, q_empty, q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_factor_r    <= FACTOR_W'(1);
      v_factor_r    <= FACTOR_W'(1);
      blk_per_row_r <= CFG_DATA_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_H_FACTOR:    h_factor_r    <= cfg_data[FACTOR_W-1:0];
        REG_V_FACTOR:    v_factor_r    <= cfg_data[FACTOR_W-1:0];
        REG_BLK_PER_ROW: blk_per_row_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  // front: accept and scale
  cur_front u_front (
    .in_item  (in_item),
    .in_push  (in_push),
    .h_factor (h_factor_r),
    .v_factor (v_factor_r),
    .q_full   (q_full),
    .job      (fr_job),
    .job_push (fr_push)
  );

  // job queue
  cur_queue #(
    .WIDTH ($bits(cur_job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_push),
    .wdata (fr_job),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_job),
    .empty (q_empty)
  );

  // back: replicate
  cur_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job         (q_job),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .blk_per_row (blk_per_row_r),
    .out_item    (out_item),
    .out_empty   (out_empty),
    .out_pop     (out_pop)
  );

  assign in_full = q_full;

endmodule

`default_nettype wire

### hdl/cur_queue.sv
// cur_queue: small register queue of jobs between front and back.
// Depends on nothing but its parameters.
`default_nettype none

module cur_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // pointer and count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  // count never exceeds depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= FULL_CNT)
    else $error("queue count out of range");

  // a push into a non-full queue without a pop grows the count
  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("queue count did not grow on push");

  // a pop from a non-empty queue without a push shrinks the count
  a_cnt_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

### hdl/cur_front.sv
// cur_front: accepts input transactions, clamps the factors and computes
// the full-resolution base coordinates. Depends on cur_pkg.
`default_nettype none

module cur_front (
  input  wire cur_pkg::cur_in_t            in_item,
  input  wire logic                        in_push,
  input  wire logic [cur_pkg::FACTOR_W-1:0] h_factor,
  input  wire logic [cur_pkg::FACTOR_W-1:0] v_factor,
  input  wire logic                        q_full,
  output cur_pkg::cur_job_t                job,
  output logic                             job_push
);

  import cur_pkg::*;

  logic [10:0]         pos_x, pos_y;
  logic [1:0]          hf_m1, vf_m1;
  logic [FACTOR_W-1:0] hf, vf;

  // effective factors
  assign hf_m1 = clamp_factor_m1(h_factor);
  assign vf_m1 = clamp_factor_m1(v_factor);
  assign hf    = {1'b0, hf_m1} + 3'd1;
  assign vf    = {1'b0, vf_m1} + 3'd1;

  // component pixel position, then scaled to the full grid
  assign pos_x = {in_item.block_col, in_item.col_in_block};
  assign pos_y = {in_item.block_row, in_item.row_in_block};

  always_comb begin
    job.sample = in_item.sample;
    job.base_x = COORD_W'({2'b0, pos_x} * {10'b0, hf});
    job.base_y = COORD_W'({2'b0, pos_y} * {10'b0, vf});
    job.hf_m1  = hf_m1;
    job.vf_m1  = vf_m1;
  end

  assign job_push = in_push && !q_full;

endmodule

`default_nettype wire

### hdl/cur_back.sv
// cur_back: walks the replica offsets of the job at the queue head and
// emits one copy per cycle into the result register while that slot is free or being drained. Depends on cur_pkg.
`default_nettype none

module cur_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cur_pkg::cur_job_t             job,
  input  wire logic                          q_empty,
  output logic                               q_pop,
  input  wire logic [cur_pkg::CFG_DATA_W-1:0] blk_per_row,
  output cur_pkg::cur_out_t                  out_item,
  output logic                               out_empty,
  input  wire logic                          out_pop
);

  import cur_pkg::*;

  logic [1:0]         ox_r, ox_nxt;
  logic [1:0]         oy_r, oy_nxt;
  logic               out_vld_r, out_vld_nxt;
  cur_out_t           out_r, res;
  logic               advance, is_last;
  logic [COORD_W-1:0] dx, dy;
  logic [18:0]        blk_sum;

  // step when a job waits and the result slot is free or being drained
  assign advance = !q_empty && (!out_vld_r || out_pop);
  assign is_last = (ox_r == job.hf_m1) && (oy_r == job.vf_m1);
  assign q_pop   = advance && is_last;

  // destination of the current copy
  assign dx      = job.base_x + COORD_W'(ox_r);
  assign dy      = job.base_y + COORD_W'(oy_r);
  assign blk_sum = ({9'b0, dy[COORD_W-1:3]} * {10'b0, blk_per_row})
                   + {9'b0, dx[COORD_W-1:3]};

  always_comb begin
    res.sample_out = job.sample;
    res.out_block  = blk_sum[15:0];
    res.out_col    = dx[2:0];
    res.out_row    = dy[2:0];
    res.last       = is_last;
  end

  // offset counters, vertical inner
  always_comb begin
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    out_vld_nxt = out_vld_r;
    if (out_pop) begin
      out_vld_nxt = 1'b0;
    end
    if (advance) begin
      out_vld_nxt = 1'b1;
      if (is_last) begin
        ox_nxt = '0;
        oy_nxt = '0;
      end else if (oy_r == job.vf_m1) begin
        oy_nxt = '0;
        ox_nxt = ox_r + 2'd1;
      end else begin
        oy_nxt = oy_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r      <= '0;
      oy_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      ox_r      <= ox_nxt;
      oy_r      <= oy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // result register, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_item  = out_r;
  assign out_empty = !out_vld_r;

  // offsets are back at zero after a job retires
  a_retire_zero: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (ox_r == 2'd0 && oy_r == 2'd0))
    else $error("offsets not cleared after last copy");

  // offsets stay inside the job's factors
  a_offs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (ox_r <= job.hf_m1 && oy_r <= job.vf_m1))
    else $error("replica offset beyond factor");

  // a retired job always leaves a last-marked copy in the result slot
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_vld_r && out_r.last))
    else $error("last copy not marked");

endmodule

`default_nettype wire

### tb/sv/replica_checker.sv
// replica_checker: watches the sample, replica and register channels of
// chroma_upsample_replicate, predicts every replica and compares it.
// Depends on cur_pkg only.
`timescale 1ns / 100ps

module replica_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic                           in_full,
  input  cur_pkg::cur_in_t               in_item,
  input  logic                           out_pop,
  input  logic                           out_empty,
  input  cur_pkg::cur_out_t              out_item,
  input  logic                           cfg_we,
  input  logic [cur_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cur_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatch_count,
  output int                             due_count
);
  import cur_pkg::*;

  // shadow copy of the factor and grid registers
  logic [2:0] h_reg;
  logic [2:0] v_reg;
  logic [8:0] row_blocks_reg;

  // replicas still owed by the block, oldest first
  cur_out_t replicas_due[$];

  // zero acts as one, five to seven act as four
  function automatic int effective_factor(input logic [2:0] f);
    int r;
    if (f == 3'd0) begin
      r = 1;
    end else if (f > 3'd4) begin
      r = 4;
    end else begin
      r = int'(f);
    end
    return r;
  endfunction

  // all replicas of one sample, horizontal offset outer, vertical inner
  task automatic expand_sample(input cur_in_t it);
    int hf;
    int vf;
    int base_x;
    int base_y;
    int dx;
    int dy;
    cur_out_t r;
    hf = effective_factor(h_reg);
    vf = effective_factor(v_reg);
    base_x = (int'(it.block_col) * 8 + int'(it.col_in_block)) * hf;
    base_y = (int'(it.block_row) * 8 + int'(it.row_in_block)) * vf;
    for (int ox = 0; ox < hf; ox++) begin
      for (int oy = 0; oy < vf; oy++) begin
        dx = base_x + ox;
        dy = base_y + oy;
        r.sample_out = it.sample;
        r.out_block  = 16'((dy / 8) * int'(row_blocks_reg) + dx / 8);
        r.out_col    = 3'(dx % 8);
        r.out_row    = 3'(dy % 8);
        r.last       = (ox == hf - 1) && (oy == vf - 1);
        replicas_due.push_back(r);
      end
    end
  endtask

  // sample all three channels at the rising edge
  always @(posedge clk) begin : watch
    cur_out_t want;
    if (!rst_n) begin
      h_reg          <= 3'd1;
      v_reg          <= 3'd1;
      row_blocks_reg <= 9'd1;
      replicas_due.delete();
      mismatch_count <= 0;
      due_count      <= 0;
    end else begin
      // replica transaction against the oldest prediction
      if (out_pop && !out_empty) begin
        if (replicas_due.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          $display("%0t: unexpected replica: sample %0d block %0d col %0d row %0d last %0b",
                   $time, out_item.sample_out, out_item.out_block, out_item.out_col,
                   out_item.out_row, out_item.last);
        end else begin
          want = replicas_due.pop_front();
          if (out_item !== want) begin
            mismatch_count <= mismatch_count + 1;
            $display("%0t: replica mismatch: expected sample %0d block %0d col %0d row %0d last %0b",
                     $time, want.sample_out, want.out_block, want.out_col, want.out_row,
                     want.last);
            $display("%0t:                   actual sample %0d block %0d col %0d row %0d last %0b",
                     $time, out_item.sample_out, out_item.out_block, out_item.out_col,
                     out_item.out_row, out_item.last);
          end
        end
      end
      // sample transaction uses the registers as they stand before this edge
      if (in_push && !in_full) begin
        expand_sample(in_item);
      end
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_H_FACTOR:    h_reg          <= cfg_data[2:0];
          REG_V_FACTOR:    v_reg          <= cfg_data[2:0];
          REG_BLK_PER_ROW: row_blocks_reg <= cfg_data[8:0];
          default: ;
        endcase
      end
      due_count <= replicas_due.size();
    end
  end

endmodule

### tb/sv/tb_chroma_upsample_replicate.sv
// tb_chroma_upsample_replicate: clock, reset, sample and register stimulus,
// replica pop pattern and verdict. Depends on cur_pkg, replica_checker and the block.
`timescale 1ns / 100ps

module tb_chroma_upsample_replicate;
  import cur_pkg::*;

  localparam int NUM_PHASES = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 120;

  typedef enum logic [1:0] {POP_ALWAYS, POP_HALF, POP_RARE, POP_MOSTLY} pop_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  cur_in_t               in_item;
  logic                  out_empty;
  cur_out_t              out_item;
  logic                  out_pop;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_count;
  int due_count;
  int cycle_count = 0;
  logic long_hold_req = 1'b0;

  // factor and grid settings per phase; phase 0 runs on the reset values
  int phase_h      [NUM_PHASES] = '{1, 2, 0, 4, 7, 1, 3, 5};
  int phase_v      [NUM_PHASES] = '{1, 2, 7, 4, 0, 2, 3, 1};
  int phase_blocks [NUM_PHASES] = '{1, 40, 0, 256, 511, 1, 255, 0};
  int phase_random [NUM_PHASES] = '{20, 60, 25, 30, 25, 30, 30, 25};

  chroma_upsample_replicate DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_item  (out_item),
    .out_pop   (out_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  replica_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_item        (in_item),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_item       (out_item),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .due_count      (due_count)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic cur_in_t make_sample(input logic [7:0] s, input logic [7:0] bc,
                                          input logic [7:0] br, input logic [2:0] c,
                                          input logic [2:0] r);
    cur_in_t it;
    it.sample       = s;
    it.block_col    = bc;
    it.block_row    = br;
    it.col_in_block = c;
    it.row_in_block = r;
    return it;
  endfunction

  // byte field leaning toward its ends
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0:       b = 8'd0;
      1:       b = 8'd255;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // offer one sample transaction and hold it until accepted
  task automatic offer_sample(input cur_in_t it);
    in_item <= it;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  // one register write; the caller lowers the write enable afterwards
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(negedge clk);
  endtask

  // replica receiver: random pop pattern, long hold on request
  initial begin
    int hold;
    int span;
    pop_mode_t mode;
    hold = 0;
    span = 0;
    mode = POP_ALWAYS;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        out_pop <= 1'b0;
        hold--;
      end else begin
        if (span == 0) begin
          mode = pop_mode_t'($urandom_range(0, 3));
          span = $urandom_range(5, 60);
        end
        span--;
        case (mode)
          POP_ALWAYS: out_pop <= 1'b1;
          POP_HALF:   out_pop <= 1'($urandom_range(0, 1));
          POP_RARE:   out_pop <= ($urandom_range(0, 3) == 0);
          default:    out_pop <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // sample and register stimulus
  initial begin
    cur_in_t directed[$];
    int sent;
    int burst;
    int gap;
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // block is idle here: set the factors and the grid width
      if (p > 0) begin
        if (p == NUM_PHASES - 1) begin
          phase_blocks[p] = $urandom_range(1, 511);
        end
        write_reg(REG_H_FACTOR, phase_h[p]);
        write_reg(REG_V_FACTOR, phase_v[p]);
        write_reg(REG_BLK_PER_ROW, phase_blocks[p]);
        cfg_we <= 1'b0;
        @(negedge clk);
      end

      // directed samples: field extremes, clamped factors, index wrap
      directed.delete();
      case (p)
        0: begin
          directed.push_back(make_sample(8'd0, 8'd0, 8'd0, 3'd0, 3'd0));
          directed.push_back(make_sample(8'd255, 8'd255, 8'd255, 3'd7, 3'd7));
          directed.push_back(make_sample(8'hAA, 8'h55, 8'hAA, 3'd5, 3'd2));
          directed.push_back(make_sample(8'h55, 8'hAA, 8'h55, 3'd2, 3'd5));
          directed.push_back(make_sample(8'd1, 8'd128, 8'd1, 3'd4, 3'd3));
        end
        2: begin
          // zero and oversized factors, zero blocks per row
          directed.push_back(make_sample(8'd255, 8'd255, 8'd255, 3'd7, 3'd7));
          directed.push_back(make_sample(8'd0, 8'd1, 8'd0, 3'd1, 3'd0));
          directed.push_back(make_sample(8'd17, 8'd0, 8'd200, 3'd0, 3'd6));
        end
        3: begin
          // 16 replicas each, block index past 16 bits
          directed.push_back(make_sample(8'd255, 8'd255, 8'd255, 3'd7, 3'd7));
          directed.push_back(make_sample(8'h80, 8'd0, 8'd255, 3'd0, 3'd7));
          directed.push_back(make_sample(8'd7, 8'd255, 8'd0, 3'd7, 3'd0));
        end
        4: begin
          directed.push_back(make_sample(8'd200, 8'd255, 8'd255, 3'd7, 3'd7));
          directed.push_back(make_sample(8'd3, 8'd64, 8'd0, 3'd3, 3'd4));
        end
        default: ;
      endcase
      foreach (directed[i]) begin
        offer_sample(directed[i]);
      end

      // hold the receiver off and keep offering so the queue fills up
      if (p == 1) begin
        long_hold_req <= 1'b1;
        @(negedge clk);
        long_hold_req <= 1'b0;
        for (int i = 0; i < 24; i++) begin
          offer_sample(make_sample(pick_byte(), pick_byte(), pick_byte(),
                                   3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))));
        end
      end

      // random samples in bursts with random gaps
      sent = 0;
      while (sent < phase_random[p]) begin
        burst = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
        for (int i = 0; i < burst && sent < phase_random[p]; i++) begin
          offer_sample(make_sample(pick_byte(), pick_byte(), pick_byte(),
                                   3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))));
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_push <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      in_push <= 1'b0;

      // wait for every owed replica
      while (due_count != 0) @(negedge clk);
    end

    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && due_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/cur_pkg.sv
hdl/cur_queue.sv
hdl/cur_front.sv
hdl/cur_back.sv
hdl/chroma_upsample_replicate.sv
tb/sv/replica_checker.sv
tb/sv/tb_chroma_upsample_replicate.sv
